// File: design/metered_dispense_controller_macros.svh
`ifndef METERED_DISPENSE_CONTROLLER_MACROS_SVH
`define METERED_DISPENSE_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MDC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MDC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mdc_pkg.sv
package mdc_pkg;

    localparam int VOL_W     = 32;
    localparam int CAL_W     = 20;
    localparam int GOAL_UL_W = 26;
    localparam int NUM_W     = 39;
    localparam int ACC_W     = 40;
    localparam int PCT_W     = 7;
    localparam int CNT_W     = 5;
    localparam int DIV_SHIFT = 6;

    localparam logic [CNT_W-1:0] MUL_STEPS = 5'd20;
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd7;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_PULSE  = 3'd1,
        FN_START  = 3'd2,
        FN_PAUSE  = 3'd3,
        FN_RESUME = 3'd4,
        FN_STOP   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DISP     = 3'd1,
        PH_PAUSED   = 3'd2,
        PH_STOPPING = 3'd3,
        PH_DONE     = 3'd4,
        PH_TIMEOUT  = 3'd5,
        PH_NOFLOW   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        CFG_UL_PER_PULSE = 3'd0,
        CFG_MARGIN       = 3'd1,
        CFG_FLOW_TMO     = 3'd2,
        CFG_NOFLOW_WIN   = 3'd3,
        CFG_MIN_PULSES   = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

endpackage

// File: design/mdc_alu.sv
module mdc_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mdc_pkg::alu_ctrl_t             ctrl,
    input  logic [mdc_pkg::VOL_W-1:0]      mul_a,
    input  logic                           mul_sat,
    input  logic [mdc_pkg::CAL_W-1:0]      mul_b,
    input  logic [mdc_pkg::NUM_W-1:0]      div_n,
    input  logic [mdc_pkg::GOAL_UL_W-1:0]  div_d,
    output mdc_pkg::alu_stat_t             stat,
    output logic [mdc_pkg::VOL_W-1:0]      product,
    output logic [mdc_pkg::PCT_W-1:0]      quotient
);

    localparam logic [mdc_pkg::ACC_W-1:0] VOL_MAX =
        mdc_pkg::ACC_W'({mdc_pkg::VOL_W{1'b1}});

    logic                           busy_reg;
    logic                           done_reg;
    mdc_pkg::alu_op_t               op_reg;
    logic [mdc_pkg::CNT_W-1:0]      cnt_reg;
    logic [mdc_pkg::ACC_W-1:0]      acc_reg;
    logic [mdc_pkg::ACC_W-1:0]      opnd_reg;
    logic [mdc_pkg::CAL_W-1:0]      mulb_reg;
    logic                           sat_reg;
    logic [mdc_pkg::PCT_W-1:0]      q_reg;

    logic [mdc_pkg::ACC_W-1:0]      add_a;
    logic [mdc_pkg::ACC_W-1:0]      add_b;
    logic                           add_cin;
    logic [mdc_pkg::ACC_W:0]        sum;

    // shared adder: shift-add for multiply, compare-subtract for divide
    always_comb
    begin
        unique case (op_reg)
            mdc_pkg::OP_MUL:
            begin
                add_a   = {acc_reg[mdc_pkg::ACC_W-2:0], 1'b0};
                add_b   = mulb_reg[mdc_pkg::CAL_W-1] ? opnd_reg : '0;
                add_cin = 1'b0;
            end
            mdc_pkg::OP_DIV:
            begin
                add_a   = acc_reg;
                add_b   = ~opnd_reg;
                add_cin = 1'b1;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, add_b} + (mdc_pkg::ACC_W+1)'(add_cin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= mdc_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == mdc_pkg::CNT_W'(1));
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                cnt_reg  <= (ctrl.op == mdc_pkg::OP_MUL) ? mdc_pkg::MUL_STEPS
                                                         : mdc_pkg::DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - mdc_pkg::CNT_W'(1);
                if (cnt_reg == mdc_pkg::CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mulb_reg <= mul_b;
            sat_reg  <= mul_sat;
            q_reg    <= '0;
            if (ctrl.op == mdc_pkg::OP_MUL)
            begin
                acc_reg  <= '0;
                opnd_reg <= mdc_pkg::ACC_W'(mul_a);
            end
            else
            begin
                acc_reg  <= mdc_pkg::ACC_W'(div_n);
                opnd_reg <= mdc_pkg::ACC_W'(div_d) << mdc_pkg::DIV_SHIFT;
            end
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                mdc_pkg::OP_MUL:
                begin
                    mulb_reg <= {mulb_reg[mdc_pkg::CAL_W-2:0], 1'b0};
                    if (sum[mdc_pkg::ACC_W:mdc_pkg::VOL_W] != '0)
                    begin
                        sat_reg <= 1'b1;
                        acc_reg <= VOL_MAX;
                    end
                    else
                    begin
                        acc_reg <= sum[mdc_pkg::ACC_W-1:0];
                    end
                end
                mdc_pkg::OP_DIV:
                begin
                    q_reg    <= {q_reg[mdc_pkg::PCT_W-2:0], sum[mdc_pkg::ACC_W]};
                    opnd_reg <= opnd_reg >> 1;
                    if (sum[mdc_pkg::ACC_W])
                    begin
                        acc_reg <= sum[mdc_pkg::ACC_W-1:0];
                    end
                end
            endcase
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = sat_reg ? {mdc_pkg::VOL_W{1'b1}} : acc_reg[mdc_pkg::VOL_W-1:0];
    assign quotient  = q_reg;

endmodule

// File: design/metered_dispense_controller.sv
// Metered dispense controller. Each event (tick, flow pulse, start, pause,
// resume, stop) is taken over in_valid/in_ready and yields one status transfer
// on out_valid/out_ready. Each event's result is computed by one shared
// 40-bit adder that runs a 20-step shift-add multiply (pulses times
// microlitres per pulse) and then a 7-step restoring divide (percent done).
// in_ready returns together with out_valid for the new result. in_ready is high
// only while the sequencer is idle; a finished result sits in the output
// register until taken, and the next event is accepted meanwhile. If that
// register is still full when the next result is ready, the sequencer holds
// and in_ready stays low.
// Configuration writes are taken every cycle.
`include "metered_dispense_controller_macros.svh"

module metered_dispense_controller #(
    parameter int PULSE_COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [15:0] target_ml,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  run_state,
    output logic        valve_open,
    output logic [31:0] dispensed_ul,
    output logic [31:0] remaining_ul,
    output logic [6:0]  progress_pct
);

    localparam int XW = (PULSE_COUNT_BITS > mdc_pkg::VOL_W) ? PULSE_COUNT_BITS
                                                            : mdc_pkg::VOL_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_APPLY = 8'b0000_0010,
        ST_MULGO = 8'b0000_0100,
        ST_MULWT = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_DIVGO = 8'b0010_0000,
        ST_DIVWT = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                             state_reg, state_next;

    logic [19:0]                        cal_reg, cal_next;
    logic [19:0]                        margin_reg, margin_next;
    logic [15:0]                        tmo_reg, tmo_next;
    logic [15:0]                        window_reg, window_next;
    logic [7:0]                         min_pulses_reg, min_pulses_next;

    mdc_pkg::phase_t                    phase_reg, phase_next;
    logic                               valve_reg, valve_next;
    logic [PULSE_COUNT_BITS-1:0]        pulse_total_reg, pulse_total_next;
    logic [15:0]                        goal_reg, goal_next;
    logic [31:0]                        since_reg, since_next;
    logic [31:0]                        active_reg, active_next;
    logic                               tick_chk_reg, tick_chk_next;

    logic [2:0]                         func_reg, func_next;
    logic [15:0]                        tgt_reg, tgt_next;
    logic [mdc_pkg::VOL_W-1:0]          vol_reg, vol_next;
    logic [mdc_pkg::GOAL_UL_W-1:0]      goal_ul_reg, goal_ul_next;
    logic [mdc_pkg::GOAL_UL_W-1:0]      limit_reg, limit_next;
    logic [mdc_pkg::NUM_W-1:0]          num_reg, num_next;
    logic [mdc_pkg::VOL_W-1:0]          rem_reg, rem_next;
    logic                               zero_goal_reg, zero_goal_next;
    logic                               full_reg, full_next;

    logic                               out_valid_reg, out_valid_next;
    logic [2:0]                         run_state_reg, run_state_next;
    logic                               valve_open_reg, valve_open_next;
    logic [31:0]                        disp_out_reg, disp_out_next;
    logic [31:0]                        rem_out_reg, rem_out_next;
    logic [6:0]                         pct_out_reg, pct_out_next;

    logic [XW-1:0]                      pulse_ext;
    logic                               pulse_hi;
    mdc_pkg::alu_ctrl_t                 alu_ctrl;
    mdc_pkg::alu_stat_t                 alu_stat;
    logic [mdc_pkg::VOL_W-1:0]          alu_product;
    logic [mdc_pkg::PCT_W-1:0]          alu_quotient;
    logic [mdc_pkg::GOAL_UL_W-1:0]      margin_ext;

    assign pulse_ext  = XW'(pulse_total_reg);
    assign pulse_hi   = ((pulse_ext >> mdc_pkg::VOL_W) != '0) && (cal_reg != '0);
    assign margin_ext = mdc_pkg::GOAL_UL_W'(margin_reg);

    mdc_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (alu_ctrl),
        .mul_a    (pulse_ext[mdc_pkg::VOL_W-1:0]),
        .mul_sat  (pulse_hi),
        .mul_b    (cal_reg),
        .div_n    (num_reg),
        .div_d    (goal_ul_reg),
        .stat     (alu_stat),
        .product  (alu_product),
        .quotient (alu_quotient)
    );

    always_comb
    begin
        state_next       = state_reg;
        cal_next         = cal_reg;
        margin_next      = margin_reg;
        tmo_next         = tmo_reg;
        window_next      = window_reg;
        min_pulses_next  = min_pulses_reg;
        phase_next       = phase_reg;
        valve_next       = valve_reg;
        pulse_total_next = pulse_total_reg;
        goal_next        = goal_reg;
        since_next       = since_reg;
        active_next      = active_reg;
        tick_chk_next    = tick_chk_reg;
        func_next        = func_reg;
        tgt_next         = tgt_reg;
        vol_next         = vol_reg;
        goal_ul_next     = goal_ul_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        zero_goal_next   = zero_goal_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        run_state_next   = run_state_reg;
        valve_open_next  = valve_open_reg;
        disp_out_next    = disp_out_reg;
        rem_out_next     = rem_out_reg;
        pct_out_next     = pct_out_reg;
        alu_ctrl.start   = 1'b0;
        alu_ctrl.op      = mdc_pkg::OP_MUL;

        limit_next = (goal_ul_reg > margin_ext) ? goal_ul_reg - margin_ext : '0;

        if (cfg_we)
        begin
            unique case (cfg_idx)
                mdc_pkg::CFG_UL_PER_PULSE: cal_next        = cfg_wdata;
                mdc_pkg::CFG_MARGIN:       margin_next     = cfg_wdata;
                mdc_pkg::CFG_FLOW_TMO:     tmo_next        = cfg_wdata[15:0];
                mdc_pkg::CFG_NOFLOW_WIN:   window_next     = cfg_wdata[15:0];
                mdc_pkg::CFG_MIN_PULSES:   min_pulses_next = cfg_wdata[7:0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    tgt_next   = target_ml;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                tick_chk_next = 1'b0;
                unique case (func_reg)
                    mdc_pkg::FN_TICK:
                    begin
                        if (phase_reg == mdc_pkg::PH_DISP)
                        begin
                            tick_chk_next = 1'b1;
                            if (active_reg != '1)
                            begin
                                active_next = active_reg + 32'd1;
                            end
                            if (since_reg != '1)
                            begin
                                since_next = since_reg + 32'd1;
                            end
                        end
                    end
                    mdc_pkg::FN_PULSE:
                    begin
                        if (pulse_total_reg != '1)
                        begin
                            pulse_total_next = pulse_total_reg + PULSE_COUNT_BITS'(1);
                        end
                        since_next = '0;
                    end
                    mdc_pkg::FN_START:
                    begin
                        goal_next        = tgt_reg;
                        pulse_total_next = '0;
                        active_next      = '0;
                        since_next       = '0;
                        phase_next       = mdc_pkg::PH_DISP;
                        valve_next       = 1'b1;
                    end
                    mdc_pkg::FN_PAUSE:
                    begin
                        if (phase_reg == mdc_pkg::PH_DISP)
                        begin
                            valve_next = 1'b0;
                            phase_next = mdc_pkg::PH_PAUSED;
                        end
                    end
                    mdc_pkg::FN_RESUME:
                    begin
                        if (phase_reg == mdc_pkg::PH_PAUSED)
                        begin
                            phase_next = mdc_pkg::PH_DISP;
                            valve_next = 1'b1;
                            since_next = '0;
                        end
                    end
                    mdc_pkg::FN_STOP:
                    begin
                        valve_next = 1'b0;
                        if (phase_reg == mdc_pkg::PH_DISP || phase_reg == mdc_pkg::PH_PAUSED)
                        begin
                            phase_next = mdc_pkg::PH_STOPPING;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_MULGO;
            end
            ST_MULGO:
            begin
                alu_ctrl.start = 1'b1;
                alu_ctrl.op    = mdc_pkg::OP_MUL;
                goal_ul_next   = mdc_pkg::GOAL_UL_W'(goal_reg) * mdc_pkg::GOAL_UL_W'(1000);
                state_next     = ST_MULWT;
            end
            ST_MULWT:
            begin
                if (alu_stat.done)
                begin
                    vol_next   = alu_product;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (tick_chk_reg)
                begin
                    priority if (vol_reg >= mdc_pkg::VOL_W'(limit_reg))
                    begin
                        valve_next = 1'b0;
                        phase_next = mdc_pkg::PH_DONE;
                    end
                    else if (since_reg > 32'(tmo_reg))
                    begin
                        valve_next = 1'b0;
                        phase_next = mdc_pkg::PH_TIMEOUT;
                    end
                    else if (active_reg > 32'(window_reg) &&
                             pulse_total_reg < PULSE_COUNT_BITS'(min_pulses_reg))
                    begin
                        valve_next = 1'b0;
                        phase_next = mdc_pkg::PH_NOFLOW;
                    end
                end
                num_next       = mdc_pkg::NUM_W'(vol_reg) * mdc_pkg::NUM_W'(100);
                rem_next       = (mdc_pkg::VOL_W'(goal_ul_reg) > vol_reg)
                               ? mdc_pkg::VOL_W'(goal_ul_reg) - vol_reg : '0;
                zero_goal_next = (goal_ul_reg == '0);
                full_next      = (vol_reg >= mdc_pkg::VOL_W'(goal_ul_reg));
                state_next     = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                alu_ctrl.start = 1'b1;
                alu_ctrl.op    = mdc_pkg::OP_DIV;
                state_next     = ST_DIVWT;
            end
            ST_DIVWT:
            begin
                if (alu_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    run_state_next  = phase_reg;
                    valve_open_next = valve_reg;
                    disp_out_next   = vol_reg;
                    rem_out_next    = rem_reg;
                    priority if (zero_goal_reg)
                    begin
                        pct_out_next = '0;
                    end
                    else if (full_reg)
                    begin
                        pct_out_next = 7'd100;
                    end
                    else
                    begin
                        pct_out_next = alu_quotient;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cal_reg         <= 20'd2222;
            margin_reg      <= '0;
            tmo_reg         <= 16'd3000;
            window_reg      <= 16'd2000;
            min_pulses_reg  <= 8'd5;
            phase_reg       <= mdc_pkg::PH_IDLE;
            valve_reg       <= 1'b0;
            pulse_total_reg <= '0;
            goal_reg        <= '0;
            since_reg       <= '0;
            active_reg      <= '0;
            tick_chk_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cal_reg         <= cal_next;
            margin_reg      <= margin_next;
            tmo_reg         <= tmo_next;
            window_reg      <= window_next;
            min_pulses_reg  <= min_pulses_next;
            phase_reg       <= phase_next;
            valve_reg       <= valve_next;
            pulse_total_reg <= pulse_total_next;
            goal_reg        <= goal_next;
            since_reg       <= since_next;
            active_reg      <= active_next;
            tick_chk_reg    <= tick_chk_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        tgt_reg        <= tgt_next;
        vol_reg        <= vol_next;
        goal_ul_reg    <= goal_ul_next;
        limit_reg      <= limit_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        zero_goal_reg  <= zero_goal_next;
        full_reg       <= full_next;
        run_state_reg  <= run_state_next;
        valve_open_reg <= valve_open_next;
        disp_out_reg   <= disp_out_next;
        rem_out_reg    <= rem_out_next;
        pct_out_reg    <= pct_out_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign run_state    = run_state_reg;
    assign valve_open   = valve_open_reg;
    assign dispensed_ul = disp_out_reg;
    assign remaining_ul = rem_out_reg;
    assign progress_pct = pct_out_reg;

    `MDC_ASSERT_IMP(a_valve_only_dispensing, out_valid && valve_open,
                    run_state == mdc_pkg::PH_DISP, "valve open outside dispensing")
    `MDC_ASSERT_IMP(a_pct_capped, out_valid, progress_pct <= 7'd100,
                    "percent done above 100")
    `MDC_ASSERT_IMP(a_rem_vs_pct, out_valid && remaining_ul != 32'd0,
                    progress_pct < 7'd100, "volume remains but percent is full")
    `MDC_ASSERT_IMP(a_alu_owned, alu_stat.busy,
                    state_reg == ST_MULWT || state_reg == ST_DIVWT,
                    "shared unit busy outside a wait state")
    `MDC_ASSERT_NXT(a_accept_applies, in_valid && in_ready, state_reg == ST_APPLY,
                    "accepted transfer not applied")

endmodule
